FILE: rtl/hgpp_pkg.sv
// ----------------------------------------------------------------------------
// hgpp_pkg
// Shared types and constants of the hex grid point picker.
// ----------------------------------------------------------------------------
`default_nettype none

package hgpp_pkg;

   // grid limits
   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;

   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   // clamped grid sizes, wide enough for the 7-bit registers and the limits
   localparam int CNT_W = 9;

   // field widths
   localparam int PTR_W    = 12;
   localparam int VIEW_W   = 17;
   localparam int RAD_W    = 10;
   localparam int GRID_W   = 7;
   localparam int CELL_W   = 6;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 10;

   // datapath widths: screen offsets, doubled y, squared distance
   localparam int DX_W = 22;
   localparam int Y2_W = 23;
   localparam int D_W  = 2 * DX_W;

   // screen center; y is kept doubled so the half row step stays exact
   localparam int SCREEN_X_MID = 1280 / 2;
   localparam int SCREEN_Y2    = 2 * (720 / 2);

   // register reset values
   localparam logic [RAD_W-1:0]  RADIUS_RST     = 10'd60;
   localparam logic [RAD_W-1:0]  HALF_WIDTH_RST = 10'd51;
   localparam logic [GRID_W-1:0] ROWS_RST       = 7'd64;
   localparam logic [GRID_W-1:0] COLS_RST       = 7'd64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS     = 4'd0,
      CSR_HALF_WIDTH = 4'd1,
      CSR_ROWS       = 4'd2,
      CSR_COLS       = 4'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW_PREP,
      ST_ROW_SQ,
      ST_COL,
      ST_DRAIN,
      ST_THRESH,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [RAD_W-1:0]  radius;
      logic [RAD_W-1:0]  half_width;
      logic [GRID_W-1:0] rows;
      logic [GRID_W-1:0] cols;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic              hit;
      logic [CELL_W-1:0] col;
      logic [CELL_W-1:0] row;
   } res_type;

endpackage

`default_nettype wire

FILE: rtl/hgpp_core.sv
// ----------------------------------------------------------------------------
// hgpp_core
// Grid search sequencer around one shared squaring multiplier: per row, one
// cell squared per cycle, checked against the running best the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hgpp_core
   import hgpp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cfg_type                  cfg,
   input  wire logic                     start,
   input  wire logic [PTR_W-1:0]         pointer_x,
   input  wire logic [PTR_W-1:0]         pointer_y,
   input  wire logic signed [VIEW_W-1:0] view_x,
   input  wire logic signed [VIEW_W-1:0] view_y,
   output logic                          idle,
   output res_type                       res,
   input  wire logic                     res_ack
);

   state_type state_ff, state_in;

   logic [ROW_W-1:0]         row_ff;
   logic [COL_W-1:0]         col_ff;
   logic [PTR_W-1:0]         px_ff, py_ff;
   logic signed [VIEW_W-1:0] vx_ff;
   logic signed [Y2_W-1:0]   y2_ff;
   logic signed [DX_W-1:0]   dx_ff, dy_ff;
   logic [D_W-1:0]           prod_ff, dy2_ff;
   logic                     cmp_valid_ff;
   logic [ROW_W-1:0]         cmp_row_ff;
   logic [COL_W-1:0]         cmp_col_ff;
   logic                     found_ff;
   logic [D_W-1:0]           best_ff;
   logic [ROW_W-1:0]         best_row_ff;
   logic [COL_W-1:0]         best_col_ff;

   logic [CNT_W-1:0] rows_eff, cols_eff, rows_last, cols_last;
   logic             grid_empty, row_last, col_last;

   logic signed [DX_W-1:0]   mul_a;
   logic signed [D_W-1:0]    mul_sq;
   logic [D_W-1:0]           cell_dist;
   logic                     better;

   logic signed [Y2_W-1:0]   y2_half, cy, y2_start, dy_full;
   logic signed [DX_W-1:0]   dx_start, odd_h;
   logic [RAD_W+1:0]         three_r;
   logic                     hit;

   // grid size, clamped to the limits
   always_comb begin
      rows_eff = (CNT_W'(cfg.rows) > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : CNT_W'(cfg.rows);
      cols_eff = (CNT_W'(cfg.cols) > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : CNT_W'(cfg.cols);
      rows_last  = rows_eff - CNT_W'(1);
      cols_last  = cols_eff - CNT_W'(1);
      grid_empty = (rows_eff == '0) || (cols_eff == '0);
      row_last   = (row_ff == rows_last[ROW_W-1:0]);
      col_last   = (col_ff == cols_last[COL_W-1:0]);
   end

   // row setup arithmetic
   always_comb begin
      y2_start = $signed(Y2_W'(SCREEN_Y2))
               - ($signed({{(Y2_W-VIEW_W){view_y[VIEW_W-1]}}, view_y}) <<< 1);
      y2_half  = y2_ff >>> 1;
      // truncate toward zero: floor shift plus one for odd negative values
      cy       = y2_half + $signed({{(Y2_W-1){1'b0}}, y2_ff[Y2_W-1] & y2_ff[0]});
      dy_full  = $signed({{(Y2_W-PTR_W){1'b0}}, py_ff}) - cy;
      odd_h    = row_ff[0] ? $signed({{(DX_W-RAD_W){1'b0}}, cfg.half_width}) : '0;
      dx_start = $signed({{(DX_W-PTR_W){1'b0}}, px_ff})
               + $signed({{(DX_W-VIEW_W){vx_ff[VIEW_W-1]}}, vx_ff})
               - $signed(DX_W'(SCREEN_X_MID))
               - odd_h;
      three_r  = {1'b0, cfg.radius, 1'b0} + {2'b00, cfg.radius};
   end

   // shared squaring unit
   always_comb begin
      case (state_ff)
         ST_ROW_SQ: mul_a = dy_ff;
         ST_THRESH: mul_a = $signed({{(DX_W-RAD_W){1'b0}}, cfg.radius});
         default:   mul_a = dx_ff;
      endcase
      mul_sq = mul_a * mul_a;
   end

   assign cell_dist = prod_ff + dy2_ff;
   assign better    = !found_ff || (cell_dist < best_ff);
   assign hit       = found_ff && (best_ff <= prod_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = grid_empty ? ST_THRESH : ST_ROW_PREP;
            end
         end
         ST_ROW_PREP: state_in = ST_ROW_SQ;
         ST_ROW_SQ:   state_in = ST_COL;
         ST_COL: begin
            if (col_last) begin
               state_in = row_last ? ST_DRAIN : ST_ROW_PREP;
            end
         end
         ST_DRAIN:  state_in = ST_THRESH;
         ST_THRESH: state_in = ST_RESULT;
         ST_RESULT: begin
            if (res_ack) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      idle = 1'b0;
      res  = '0;
      case (state_ff)
         ST_IDLE: idle = 1'b1;
         ST_RESULT: begin
            res.valid = 1'b1;
            res.hit   = hit;
            res.col   = hit ? CELL_W'(best_col_ff) : '0;
            res.row   = hit ? CELL_W'(best_row_ff) : '0;
         end
         default: idle = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_valid_ff <= (state_ff == ST_COL);
         if (state_ff == ST_IDLE && start) begin
            found_ff <= 1'b0;
         end else if (cmp_valid_ff && better) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_valid_ff && better) begin
         best_ff     <= cell_dist;
         best_row_ff <= cmp_row_ff;
         best_col_ff <= cmp_col_ff;
      end
      cmp_row_ff <= row_ff;
      cmp_col_ff <= col_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               px_ff  <= pointer_x;
               py_ff  <= pointer_y;
               vx_ff  <= view_x;
               y2_ff  <= y2_start;
               row_ff <= '0;
               col_ff <= '0;
            end
         end
         ST_ROW_PREP: begin
            dx_ff  <= dx_start;
            dy_ff  <= dy_full[DX_W-1:0];
            y2_ff  <= y2_ff + $signed({{(Y2_W-RAD_W-2){1'b0}}, three_r});
            col_ff <= '0;
         end
         ST_ROW_SQ: begin
            dy2_ff <= mul_sq[D_W-1:0];
         end
         ST_COL: begin
            prod_ff <= mul_sq[D_W-1:0];
            dx_ff   <= dx_ff - $signed({{(DX_W-RAD_W-1){1'b0}}, cfg.half_width, 1'b0});
            col_ff  <= col_ff + COL_W'(1);
            if (col_last) begin
               row_ff <= row_ff + ROW_W'(1);
            end
         end
         ST_THRESH: begin
            prod_ff <= mul_sq[D_W-1:0];
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/hex_grid_point_picker.sv
// ----------------------------------------------------------------------------
// hex_grid_point_picker
// Finds the offset-row hexagon cell whose screen center is nearest a pointer.
// ----------------------------------------------------------------------------
// One item at a time: an accepted item is searched to the end, and its result
// handed on, before the next one can be taken; when either grid size is zero
// the cell search is skipped and a miss is reported. The search visits one
// cell per cycle through a single shared squaring multiplier, after per-row
// setup states ST_ROW_PREP and ST_ROW_SQ for the row's vertical offset and its
// square. The result waits in an output register, so a new item is accepted
// while the previous result is still pending. Registers are written through
// the csr_ channel, which is always ready; write them only while the block is idle.
`default_nettype none

module hex_grid_point_picker
   import hgpp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,

   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [PTR_W-1:0]         req_pointer_x,
   input  wire logic [PTR_W-1:0]         req_pointer_y,
   input  wire logic signed [VIEW_W-1:0] req_view_x,
   input  wire logic signed [VIEW_W-1:0] req_view_y,

   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_hit,
   output logic [CELL_W-1:0]             rsp_cell_col,
   output logic [CELL_W-1:0]             rsp_cell_row,

   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DAT_W-1:0]     csr_wdata
);

   cfg_type           cfg_ff;
   res_type           res;
   logic              core_idle;
   logic              start;
   logic              res_ack;
   logic              rsp_valid_ff;
   logic              rsp_hit_ff;
   logic [CELL_W-1:0] rsp_col_ff, rsp_row_ff;

   assign csr_ready = 1'b1;
   assign req_ready = core_idle;
   assign start     = req_valid && core_idle;
   assign res_ack   = res.valid && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radius     <= RADIUS_RST;
         cfg_ff.half_width <= HALF_WIDTH_RST;
         cfg_ff.rows       <= ROWS_RST;
         cfg_ff.cols       <= COLS_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RADIUS:     cfg_ff.radius     <= csr_wdata[RAD_W-1:0];
            CSR_HALF_WIDTH: cfg_ff.half_width <= csr_wdata[RAD_W-1:0];
            CSR_ROWS:       cfg_ff.rows       <= csr_wdata[GRID_W-1:0];
            CSR_COLS:       cfg_ff.cols       <= csr_wdata[GRID_W-1:0];
            default: begin
            end
         endcase
      end
   end

   hgpp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .start     (start),
      .pointer_x (req_pointer_x),
      .pointer_y (req_pointer_y),
      .view_x    (req_view_x),
      .view_y    (req_view_y),
      .idle      (core_idle),
      .res       (res),
      .res_ack   (res_ack)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ack) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ack) begin
         rsp_hit_ff <= res.hit;
         rsp_col_ff <= res.col;
         rsp_row_ff <= res.row;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_cell_col = rsp_col_ff;
   assign rsp_cell_row = rsp_row_ff;

endmodule

`default_nettype wire

FILE: rtl/hgpp_checker.sv
// ----------------------------------------------------------------------------
// hgpp_checker
// Port-level checks of the hex grid point picker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hgpp_checker
   import hgpp_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic                     rsp_hit,
   input wire logic [CELL_W-1:0]        rsp_cell_col,
   input wire logic [CELL_W-1:0]        rsp_cell_row
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
         && $stable(rsp_cell_col) && $stable(rsp_cell_row))
      else $error("stalled result changed");

   // a miss reports cell zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_cell_col == '0 && rsp_cell_row == '0)
      else $error("miss with nonzero cell");

   // the search is busy right after an item is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accept");

   // no result can appear the cycle after an item is taken
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result too early");

endmodule

bind hex_grid_point_picker hgpp_checker u_hgpp_checker (.*);

`default_nettype wire
